[rtl/core/chp_pkg.sv]
// shared constants, types and helper functions for the color histogram block
`timescale 1ns / 1ps

package chp_pkg;

    localparam int COUNT_WIDTH   = 21;
    localparam int BIN_COUNT     = 64;
    localparam int BIN_W         = $clog2(BIN_COUNT);
    localparam int PCT_W         = 7;
    localparam int NUM_W         = COUNT_WIDTH + PCT_W;
    localparam int SAMPLE_W      = 8;
    localparam int COMP_W        = 2;
    localparam int TOP_W         = 2;
    localparam int PERCENT_SCALE = 100;

    localparam logic [COMP_W-1:0] COMP_RESET = 2'd3;
    localparam logic [COMP_W-1:0] COMP_RED   = 2'd1;
    localparam logic [COMP_W-1:0] COMP_GREEN = 2'd2;
    localparam logic [COMP_W-1:0] COMP_BLUE  = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_W-1:0]       bin_t;
    typedef logic [PCT_W-1:0]       pct_t;
    typedef logic [NUM_W-1:0]       num_t;

    typedef struct packed {
        logic   start;
        count_t count;
        count_t total;
    } div_req_t;

    typedef struct packed {
        logic done;
        pct_t pct;
    } div_rsp_t;

    function automatic bin_t bin_of(
        input logic [SAMPLE_W-1:0] r,
        input logic [SAMPLE_W-1:0] g,
        input logic [SAMPLE_W-1:0] b,
        input logic [COMP_W-1:0]   cc
    );
        logic [TOP_W-1:0] rt;
        logic [TOP_W-1:0] gt;
        logic [TOP_W-1:0] bt;
        rt = (cc >= COMP_RED)   ? r[SAMPLE_W-1 -: TOP_W] : '0;
        gt = (cc >= COMP_GREEN) ? g[SAMPLE_W-1 -: TOP_W] : '0;
        bt = (cc >= COMP_BLUE)  ? b[SAMPLE_W-1 -: TOP_W] : '0;
        return {rt, gt, bt};
    endfunction

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

    function automatic num_t times_scale(input count_t c);
        return num_t'(c) * num_t'(PERCENT_SCALE);
    endfunction

endpackage

[rtl/core/chp_pixel_if.sv]
// pixel request channel
`timescale 1ns / 1ps

interface chp_pixel_if
    import chp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

[rtl/core/chp_result_if.sv]
// histogram result channel
`timescale 1ns / 1ps

interface chp_result_if
    import chp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] bin_index;
    logic [PCT_W-1:0] percent;
    logic             last_bin;

    modport source (output valid, bin_index, percent, last_bin, input ready);
    modport sink   (input valid, bin_index, percent, last_bin, output ready);
endinterface

[rtl/core/chp_cfg_if.sv]
// component count configuration write channel
`timescale 1ns / 1ps

interface chp_cfg_if
    import chp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] component_count;

    modport source (output valid, component_count, input ready);
    modport sink   (input valid, component_count, output ready);
endinterface

[rtl/core/chp_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module chp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/chp_pct_unit.sv]
// restoring divider giving floor(count*100/total), one quotient bit per cycle
`timescale 1ns / 1ps

module chp_pct_unit
    import chp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(PCT_W);

    num_t              rem_reg,  rem_next;
    num_t              dvs_reg,  dvs_next;
    pct_t              q_reg,    q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = (rem_reg >= dvs_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = times_scale(req.count);
            dvs_next  = num_t'(req.total) << (PCT_W - 1);
            q_next    = '0;
            step_next = STEP_W'(PCT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dvs_reg) : rem_reg;
            dvs_next = dvs_reg >> 1;
            q_next   = {q_reg[PCT_W-2:0], ge};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.pct  = q_reg;

endmodule

[rtl/core/color_histogram_percent.sv]
// top level of the 64-bin color histogram with percent report
`timescale 1ns / 1ps

// Pixels arrive on the pixel channel (red, green, blue, last_pixel). For each
// pixel, the accept cycle reads its bin from the count RAM and the next cycle
// writes the saturated increment back; ready is low during it.
// The cfg channel is always ready and sets component_count (reset value 3);
// write it only while no image is being reported.
// After the pixel marked last is counted, the block reports all 64 bins in
// order on the result channel, then clears its counts and takes pixels again.
// Each bin passes through a RAM read, a load of count*100 into the divider,
// 7 restoring divide steps plus a done flag, and the placing of the result.
// The result sits in an output register; a stalled receiver holds the report
// at the current bin with no loss. Bin counts are cleared by per-bin valid
// flags, so reset and the end of a report need no clearing sweep.
// Reset clears all counts and flags and leaves the block ready for pixels.
module color_histogram_percent
    import chp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    chp_pixel_if.sink       pixel,
    chp_cfg_if.sink         cfg,
    chp_result_if.source    result
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INC  = 6'b000010,
        S_READ = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t                 state_reg,   state_next;
    logic [COMP_W-1:0]      cc_reg;
    count_t                 total_reg,   total_next;
    bin_t                   bin_reg,     bin_next;
    logic                   last_reg,    last_next;
    logic [BIN_COUNT-1:0]   valid_reg,   valid_next;
    logic                   rvld_reg;
    logic                   ovalid_reg,  ovalid_next;
    bin_t                   obin_reg,    obin_next;
    pct_t                   opct_reg,    opct_next;
    logic                   olast_reg,   olast_next;

    logic     pix_acc;
    logic     slot_free;
    bin_t     raddr;
    count_t   rdata;
    count_t   cur_count;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign pixel.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign pix_acc     = pixel.valid && pixel.ready;
    assign slot_free   = !ovalid_reg || result.ready;

    assign raddr = (state_reg == S_IDLE)
                 ? bin_of(pixel.red, pixel.green, pixel.blue, cc_reg)
                 : bin_reg;
    assign cur_count = rvld_reg ? rdata : '0;

    chp_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT)
    ) u_counts (
        .clk   (clk),
        .we    (state_reg == S_INC),
        .waddr (bin_reg),
        .wdata (sat_inc(cur_count)),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign div_req.start = (state_reg == S_LOAD);
    assign div_req.count = cur_count;
    assign div_req.total = total_reg;

    chp_pct_unit u_pct (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        bin_next    = bin_reg;
        last_next   = last_reg;
        valid_next  = valid_reg;
        ovalid_next = ovalid_reg;
        obin_next   = obin_reg;
        opct_next   = opct_reg;
        olast_next  = olast_reg;
        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (pix_acc)
                begin
                    bin_next   = raddr;
                    last_next  = pixel.last_pixel;
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                total_next          = sat_inc(total_reg);
                valid_next[bin_reg] = 1'b1;
                if (last_reg)
                begin
                    bin_next   = '0;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    obin_next   = bin_reg;
                    opct_next   = div_rsp.pct;
                    olast_next  = (bin_reg == '1);
                    if (bin_reg == '1)
                    begin
                        valid_next = '0;
                        total_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        bin_next   = bin_reg + bin_t'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cc_reg     <= COMP_RESET;
            total_reg  <= '0;
            bin_reg    <= '0;
            last_reg   <= 1'b0;
            valid_reg  <= '0;
            rvld_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            bin_reg    <= bin_next;
            last_reg   <= last_next;
            valid_reg  <= valid_next;
            rvld_reg   <= valid_reg[raddr];
            ovalid_reg <= ovalid_next;
            if (cfg.valid && cfg.ready)
            begin
                cc_reg <= cfg.component_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        obin_reg  <= obin_next;
        opct_reg  <= opct_next;
        olast_reg <= olast_next;
    end

    assign result.valid     = ovalid_reg;
    assign result.bin_index = obin_reg;
    assign result.percent   = opct_reg;
    assign result.last_bin  = olast_reg;

`ifndef NO_ASSERTIONS
    a_pixel_to_inc: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> state_reg == S_INC)
        else $error("accepted pixel did not move to the increment step");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> total_reg != '0)
        else $error("percent division started with an empty total");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result appeared outside the emit step");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> div_rsp.pct <= pct_t'(PERCENT_SCALE))
        else $error("percent above full scale");
`endif

endmodule
